// File: hw/rtl/rcpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM pulse capture package
// Shared constants, payload structs and register codes for the pulse
// capture lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

   localparam int CHANNELS          = 8;
   localparam int CRITICAL_CHANNELS = 4;
   localparam int LINE_BITS         = 8;

   localparam int STAMP_W   = 32;
   localparam int WIDTH_W   = 12;
   localparam int TIMEOUT_W = 24;
   localparam int LEVEL_W   = 12;
   localparam int QUERY_W   = 4;
   localparam int QWIDTH_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [STAMP_W-1:0] PULSE_MIN = STAMP_W'(900);
   localparam logic [STAMP_W-1:0] PULSE_MAX = STAMP_W'(2200);

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(500000);
   localparam logic [LEVEL_W-1:0]   OFF_RESET     = LEVEL_W'(1300);
   localparam logic [LEVEL_W-1:0]   ON_RESET      = LEVEL_W'(1700);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAILSAFE_TIMEOUT = 2'd0,
      CSR_SWITCH_OFF       = 2'd1,
      CSR_SWITCH_ON        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] line_levels;
      logic [STAMP_W-1:0]   now_us;
      logic [QUERY_W-1:0]   query_channel;
      logic [QWIDTH_W-1:0]  fallback_width;
   } req_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] updated_mask;
      logic [LINE_BITS-1:0] fresh_mask;
      logic                 frame_fresh;
      logic [QWIDTH_W-1:0]  query_width;
      logic                 query_fresh;
      logic [LINE_BITS-1:0] switch_mask;
   } rsp_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] failsafe_timeout;
      logic [LEVEL_W-1:0]   switch_off;
      logic [LEVEL_W-1:0]   switch_on;
   } cfg_type;

   typedef struct packed {
      logic               updated;
      logic               fresh;
      logic               switch_on;
      logic [WIDTH_W-1:0] width;
   } lane_out_type;

   // Channel three powers up at 1000 us, every other channel at 1500 us.
   function automatic logic [WIDTH_W-1:0] reset_width(input int lane);
      logic [WIDTH_W-1:0] w;
      w = (lane == 2) ? WIDTH_W'(1000) : WIDTH_W'(1500);
      return w;
   endfunction

endpackage

// File: hw/rtl/rcpwm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM capture lane
// Edge detection, width measurement, width store, freshness test and
// hysteresis switch for one receiver channel.
// ----------------------------------------------------------------------------
module rcpwm_lane
   import rcpwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 line_level,
   input  logic [STAMP_W-1:0]   now_us,
   input  cfg_type              cfg,
   input  logic [WIDTH_W-1:0]   init_width,
   output lane_out_type         lane_out
);

   logic               prev_level_ff;
   logic [STAMP_W-1:0] rise_stamp_ff;
   logic [WIDTH_W-1:0] width_ff,  width_in;
   logic [STAMP_W-1:0] update_stamp_ff;
   logic               switch_ff, switch_in;

   logic               rising;
   logic               falling;
   logic [STAMP_W-1:0] pulse;
   logic [STAMP_W-1:0] age;
   logic               take;

   assign rising  = line_level & ~prev_level_ff;
   assign falling = prev_level_ff & ~line_level;
   assign pulse   = now_us - rise_stamp_ff;
   assign age     = now_us - update_stamp_ff;
   assign take    = falling && (pulse >= PULSE_MIN) && (pulse <= PULSE_MAX);

   // The off test wins when the two levels cross.
   always_comb begin
      width_in  = pulse[WIDTH_W-1:0];
      switch_in = switch_ff;
      if (width_in <= cfg.switch_off) begin
         switch_in = 1'b0;
      end else if (width_in >= cfg.switch_on) begin
         switch_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff   <= 1'b0;
         rise_stamp_ff   <= '0;
         width_ff        <= init_width;
         update_stamp_ff <= '0;
         switch_ff       <= 1'b0;
      end else if (accept) begin
         prev_level_ff <= line_level;
         if (rising) begin
            rise_stamp_ff <= now_us;
         end
         if (take) begin
            width_ff        <= width_in;
            update_stamp_ff <= now_us;
            switch_ff       <= switch_in;
         end
      end
   end

   // A channel that updates on this sample has age zero and is fresh.
   always_comb begin
      lane_out.updated   = take;
      lane_out.fresh     = take || (age <= {{(STAMP_W-TIMEOUT_W){1'b0}}, cfg.failsafe_timeout});
      lane_out.switch_on = take ? switch_in : switch_ff;
      lane_out.width     = take ? width_in : width_ff;
   end

endmodule

// File: hw/rtl/rcpwm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM result merge
// Gathers the lane results into masks, frame freshness and the
// single-channel read with fallback.
// ----------------------------------------------------------------------------
module rcpwm_merge
   import rcpwm_pkg::*;
(
   input  lane_out_type          lanes [CHANNELS],
   input  logic [QUERY_W-1:0]    query_channel,
   input  logic [QWIDTH_W-1:0]   fallback_width,
   output rsp_type               result
);

   logic               query_ok;
   logic               frame;
   logic               sel_fresh;
   logic [WIDTH_W-1:0] sel_width;
   logic               width_ok;

   assign query_ok = (query_channel != '0) && (int'(query_channel) <= CHANNELS);

   always_comb begin
      result    = '0;
      frame     = 1'b1;
      sel_fresh = 1'b0;
      sel_width = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i < LINE_BITS) begin
            result.updated_mask[i] = lanes[i].updated;
            result.fresh_mask[i]   = lanes[i].fresh;
            result.switch_mask[i]  = lanes[i].switch_on;
         end
         if (i < CRITICAL_CHANNELS && !lanes[i].fresh) begin
            frame = 1'b0;
         end
         if (query_channel == QUERY_W'(i + 1)) begin
            sel_fresh = lanes[i].fresh;
            sel_width = lanes[i].width;
         end
      end
      width_ok = ({{(STAMP_W-WIDTH_W){1'b0}}, sel_width} >= PULSE_MIN) &&
                 ({{(STAMP_W-WIDTH_W){1'b0}}, sel_width} <= PULSE_MAX);
      result.frame_fresh = frame;
      result.query_fresh = query_ok && sel_fresh;
      result.query_width = (query_ok && width_ok) ?
                           {{(QWIDTH_W-WIDTH_W){1'b0}}, sel_width} : fallback_width;
   end

endmodule

// File: hw/rtl/rc_pwm_pulse_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM pulse capture
// Eight-channel RC receiver pulse-width capture with freshness and
// hysteresis switch outputs.
// ----------------------------------------------------------------------------
// Each request transaction carries one timestamped sample of the receiver
// lines. One capture lane per channel sees its own line, stores the rise time
// on a rising edge and on a falling edge measures the width, which is kept
// only when it lies from 900 to 2200 us; a kept width also restamps the
// channel and moves its on/off switch across the hysteresis band. The block
// takes one transaction per clock with no bubbles while req_stall is low:
// every lane does its edge handling, width subtract and age compare in the
// cycle the sample is taken, so the next sample can follow at once.
// A response reaches the response port through stage one, which
// holds the lane results, then the response register, into which the merge
// stage forms the masks, frame freshness and the single-channel read. The
// response register decouples the two sides, so the block keeps accepting
// while a finished response waits, and only stalls requests when both
// stages are full and the response side is stalled. Configuration registers
// are written through the csr port; the user must do so only while the block
// is idle (not enforced by the block); an index with no register is ignored.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_capture
   import rcpwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,

   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff;

   // Handshake and stage control.
   logic accept;
   logic out_move;
   logic s1_free;
   logic s1_move;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Stage one: lane results plus the query fields of the same transaction.
   lane_out_type          lane_out  [CHANNELS];
   lane_out_type          lane_ff   [CHANNELS];
   logic [QUERY_W-1:0]    query_ff;
   logic [QWIDTH_W-1:0]   fallback_ff;

   rsp_type merged;
   rsp_type rsp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.failsafe_timeout <= TIMEOUT_RESET;
         cfg_ff.switch_off       <= OFF_RESET;
         cfg_ff.switch_on        <= ON_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FAILSAFE_TIMEOUT: cfg_ff.failsafe_timeout <= csr_data[TIMEOUT_W-1:0];
            CSR_SWITCH_OFF:       cfg_ff.switch_off       <= csr_data[LEVEL_W-1:0];
            CSR_SWITCH_ON:        cfg_ff.switch_on        <= csr_data[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The response register frees when it is empty or being taken; stage one
   // frees when it is empty or moving into the response register.
   assign out_move     = !rsp_valid_ff || !rsp_stall;
   assign s1_move      = s1_valid_ff && out_move;
   assign s1_free      = !s1_valid_ff || out_move;
   assign req_stall    = !s1_free;
   assign accept       = req_valid && s1_free;
   assign s1_valid_in  = accept || (s1_valid_ff && !out_move);
   assign rsp_valid_in = out_move ? s1_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // One capture lane per channel. Channels beyond the sampled lines never
   // see an edge.
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic level;
      if (i < LINE_BITS) begin : g_line
         assign level = req_payload.line_levels[i];
      end else begin : g_none
         assign level = 1'b0;
      end

      rcpwm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .line_level (level),
         .now_us     (req_payload.now_us),
         .cfg        (cfg_ff),
         .init_width (reset_width(i)),
         .lane_out   (lane_out[i])
      );

      always_ff @(posedge clock) begin
         if (accept) begin
            lane_ff[i] <= lane_out[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff    <= req_payload.query_channel;
         fallback_ff <= req_payload.fallback_width;
      end
   end

   rcpwm_merge u_merge (
      .lanes          (lane_ff),
      .query_channel  (query_ff),
      .fallback_width (fallback_ff),
      .result         (merged)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff <= merged;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // A channel that takes a width on this sample has age zero.
   a_updated_is_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.updated_mask & ~rsp_payload.fresh_mask) == '0))
      else $error("updated channel reported stale");

   // Frame freshness follows the critical channels' freshness bits.
   a_frame_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.frame_fresh ==
                     (&rsp_payload.fresh_mask[CRITICAL_CHANNELS-1:0])))
      else $error("frame freshness disagrees with channel freshness");

   // Nothing leaves the block in the cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !s1_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// File: tb/tb_rc_pwm_pulse_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM pulse capture testbench
// Drives timestamped line samples into the pulse capture block and checks
// every response against a cycle-free prediction of the edge handling, the
// width window, the hysteresis switches, freshness and the channel read.
// ----------------------------------------------------------------------------
// The run is built from phases. Each phase programs the three registers
// while the block is idle, picks a flow-control style for both channels and
// then queues a mix of well-formed receiver frames (the selected lines rise,
// then fall one after another with widths around the window and switch edges)
// and random noise samples. A driver on the falling clock edge feeds the
// request channel from the queue of pending samples, and a monitor on the
// rising clock edge records accepted samples, runs the prediction and
// compares accepted responses with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_rc_pwm_pulse_capture;
   import rcpwm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 4;
   localparam int PRINT_LIMIT = 100;

   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   rc_pwm_pulse_capture dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // Samples waiting to be driven and responses that the block still owes.
   req_type pending_samples[$];
   rsp_type expected_rsp[$];

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  rsp_count      = 0;
   int  csr_count      = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  send_idle_pct  = 0;
   int  rsp_stall_pct  = 0;
   logic req_fire      = 1'b0;

   // Predicted block state and the mirror of its registers.
   logic [TIMEOUT_W-1:0] cfg_timeout;
   logic [LEVEL_W-1:0]   cfg_off;
   logic [LEVEL_W-1:0]   cfg_on;
   logic [7:0]           lines_prev;
   logic [STAMP_W-1:0]   rise_at   [CHANNELS];
   logic [WIDTH_W-1:0]   width_held[CHANNELS];
   logic [STAMP_W-1:0]   stamp_at  [CHANNELS];
   logic                 switch_on_q[CHANNELS];

   // Stimulus generator state, kept by the initial block only.
   logic [7:0]  gen_levels = '0;
   logic [31:0] gen_now    = '0;
   logic [31:0] phase_timeout;
   logic [31:0] phase_off;
   logic [31:0] phase_on;

   task automatic clear_capture_state();
      int i;
      cfg_timeout = TIMEOUT_RESET;
      cfg_off     = OFF_RESET;
      cfg_on      = ON_RESET;
      lines_prev  = '0;
      for (i = 0; i < CHANNELS; i++) begin
         rise_at[i]     = '0;
         width_held[i]  = (i == 2) ? WIDTH_W'(1000) : WIDTH_W'(1500);
         stamp_at[i]    = '0;
         switch_on_q[i] = 1'b0;
      end
   endtask

   function automatic logic channel_fresh(input int ch, input logic [31:0] now);
      logic [31:0] age;
      age = now - stamp_at[ch];
      return age <= {8'd0, cfg_timeout};
   endfunction

   // Edges of the sample are applied first; every output is then taken from
   // the updated state at this sample's own timestamp.
   task automatic capture_sample(input req_type s, output rsp_type r);
      logic [7:0]  rising;
      logic [7:0]  falling;
      logic [31:0] w;
      int          i;
      int          qi;
      rising  = s.line_levels & ~lines_prev;
      falling = lines_prev & ~s.line_levels;
      r = '0;
      for (i = 0; i < CHANNELS; i++) begin
         if (rising[i]) begin
            rise_at[i] = s.now_us;
         end else if (falling[i]) begin
            w = s.now_us - rise_at[i];
            if (w >= PULSE_MIN && w <= PULSE_MAX) begin
               width_held[i]     = w[WIDTH_W-1:0];
               stamp_at[i]       = s.now_us;
               r.updated_mask[i] = 1'b1;
               // The off test is checked first, so crossed levels favor off.
               if (w <= {20'd0, cfg_off}) begin
                  switch_on_q[i] = 1'b0;
               end else if (w >= {20'd0, cfg_on}) begin
                  switch_on_q[i] = 1'b1;
               end
            end
         end
      end
      lines_prev = s.line_levels;

      r.frame_fresh = 1'b1;
      for (i = 0; i < CHANNELS; i++) begin
         r.fresh_mask[i]  = channel_fresh(i, s.now_us);
         r.switch_mask[i] = switch_on_q[i];
         if (i < CRITICAL_CHANNELS && !r.fresh_mask[i]) begin
            r.frame_fresh = 1'b0;
         end
      end

      r.query_width = s.fallback_width;
      r.query_fresh = 1'b0;
      if (s.query_channel >= 1 && s.query_channel <= CHANNELS) begin
         qi = int'(s.query_channel) - 1;
         if (width_held[qi] >= PULSE_MIN && width_held[qi] <= PULSE_MAX) begin
            r.query_width = QWIDTH_W'(width_held[qi]);
         end
         r.query_fresh = channel_fresh(qi, s.now_us);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("cycle %0d: response %0d %s got 0x%0h, expected 0x%0h",
                  cycle_count, rsp_count, field, got, want);
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(field, got, want);
      end
   endtask

   // Driver: a new sample is offered only once the previous one has been
   // taken, so a stalled payload never changes.
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (!reset && pending_samples.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_samples.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Monitor: register writes, accepted samples and accepted responses are
   // all seen at the rising edge, where the block sees them too.
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_FAILSAFE_TIMEOUT: cfg_timeout = csr_data[TIMEOUT_W-1:0];
               CSR_SWITCH_OFF:       cfg_off     = csr_data[LEVEL_W-1:0];
               CSR_SWITCH_ON:        cfg_on      = csr_data[LEVEL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            capture_sample(req_payload, predicted);
            expected_rsp.push_back(predicted);
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", 32'd0, 32'd0);
            end else begin
               want = expected_rsp.pop_front();
               compare_field("updated_mask", rsp_payload.updated_mask, want.updated_mask);
               compare_field("fresh_mask", rsp_payload.fresh_mask, want.fresh_mask);
               compare_field("frame_fresh", rsp_payload.frame_fresh, want.frame_fresh);
               compare_field("query_width", rsp_payload.query_width, want.query_width);
               compare_field("query_fresh", rsp_payload.query_fresh, want.query_fresh);
               compare_field("switch_mask", rsp_payload.switch_mask, want.switch_mask);
            end
            rsp_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_rsp.size());
         $display("** rc_pwm_pulse_capture: FAILED **");
         $finish;
      end
   end

   task automatic queue_sample(input logic [7:0] lv, input logic [31:0] t,
                               input logic [3:0] q, input logic [15:0] fb);
      req_type s;
      s.line_levels    = lv;
      s.now_us         = t;
      s.query_channel  = q;
      s.fallback_width = fb;
      pending_samples.push_back(s);
      queued_count++;
      gen_levels = lv;
   endtask

   task automatic queue_random_query(input logic [7:0] lv, input logic [31:0] t);
      queue_sample(lv, t, 4'($urandom_range(15)), 16'($urandom));
   endtask

   // Widths cluster on the window edges and on the current switch levels,
   // with a share of clearly rejected and of shared values.
   function automatic logic [31:0] pick_width();
      case ($urandom_range(9))
         0:       return 32'(899 + $urandom_range(2));
         1:       return 32'(2199 + $urandom_range(2));
         2:       return ($urandom_range(1) == 0) ? 32'($urandom_range(65535)) : $urandom;
         3:       return phase_off + 32'($urandom_range(2)) - 32'd1;
         4:       return phase_on + 32'($urandom_range(2)) - 32'd1;
         5:       return 32'd1500;
         default: return 32'($urandom_range(2200, 900));
      endcase
   endfunction

   // One receiver frame: the selected lines rise together, then fall in
   // order of width; lines with equal widths fall in the same sample.
   task automatic queue_frame();
      logic [7:0]  mask;
      logic [7:0]  lv;
      logic [31:0] w[CHANNELS];
      logic [31:0] t0;
      logic [31:0] t_fall;
      int          order[CHANNELS];
      int          i;
      int          j;
      int          k;
      if (gen_levels != 8'd0) begin
         gen_now = gen_now + 32'($urandom_range(5000, 1));
         queue_random_query(8'd0, gen_now);
      end
      mask = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
      t0   = gen_now;
      queue_random_query(mask, t0);
      for (i = 0; i < CHANNELS; i++) begin
         w[i]     = pick_width();
         order[i] = i;
      end
      for (i = 0; i < CHANNELS - 1; i++) begin
         for (j = i + 1; j < CHANNELS; j++) begin
            if (w[order[j]] < w[order[i]]) begin
               k        = order[i];
               order[i] = order[j];
               order[j] = k;
            end
         end
      end
      lv     = mask;
      t_fall = t0;
      for (k = 0; k < CHANNELS; k++) begin
         i = order[k];
         if (mask[i]) begin
            lv[i]  = 1'b0;
            t_fall = t0 + w[i];
            if (k == CHANNELS - 1 || w[order[k + 1]] != w[i] || !mask[order[k + 1]]) begin
               queue_random_query(lv, t_fall);
               if ($urandom_range(4) == 0) begin
                  queue_random_query(lv, t_fall + 32'($urandom_range(50)));
               end
            end
         end
      end
      if (lv != 8'd0) begin
         queue_random_query(8'd0, t_fall + 32'd1);
      end
      // Now and then probe freshness exactly at and just past the timeout.
      if ($urandom_range(5) == 0) begin
         queue_random_query(8'd0, t_fall + phase_timeout);
         queue_random_query(8'd0, t_fall + phase_timeout + 32'd1);
      end
      case ($urandom_range(7))
         0:       gen_now = $urandom;
         1:       gen_now = t_fall + phase_timeout + 32'($urandom_range(30000));
         default: gen_now = t_fall + 32'($urandom_range(25000, 2000));
      endcase
   endtask

   task automatic queue_noise();
      logic [7:0]  lv;
      logic [31:0] t;
      lv = 8'($urandom);
      t  = ($urandom_range(3) == 0) ? $urandom : gen_now + 32'($urandom_range(3000));
      queue_random_query(lv, t);
      gen_now = t;
   endtask

   task automatic queue_random_samples(input int n);
      int target;
      target = queued_count + n;
      while (queued_count < target) begin
         if ($urandom_range(9) < 7) begin
            queue_frame();
         end else begin
            queue_noise();
         end
      end
   endtask

   // Returns on a falling edge once every queued sample has been taken and
   // every response has come, after a further tail for the pipeline.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (accepted_count != queued_count || expected_rsp.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Each write is followed by a quiet interval with the enable low, so the
   // enable never rises and falls within one time step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      csr_count++;
   endtask

   task automatic run_phase(input logic [31:0] timeout, input logic [31:0] off_lvl,
                            input logic [31:0] on_lvl, input int send_pct,
                            input int stall_pct, input int n, input bit poke_unused,
                            input bit pause_midway);
      wait_idle();
      write_csr(CSR_FAILSAFE_TIMEOUT, timeout);
      write_csr(CSR_SWITCH_OFF, off_lvl);
      write_csr(CSR_SWITCH_ON, on_lvl);
      if (poke_unused) begin
         write_csr(CSR_UNUSED, $urandom);
      end
      @(posedge clock);
      phase_timeout = timeout;
      phase_off     = off_lvl;
      phase_on      = on_lvl;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (pause_midway) begin
         // The sender holds off here until the block has answered everything.
         queue_random_samples(n / 2);
         wait_idle();
         @(posedge clock);
         queue_random_samples(n - n / 2);
      end else begin
         queue_random_samples(n);
      end
   endtask

   initial begin
      clear_capture_state();
      phase_timeout = 32'(TIMEOUT_RESET);
      phase_off     = 32'(OFF_RESET);
      phase_on      = 32'(ON_RESET);
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples at the reset settings. The very first sample has
      // every line high, so all channels see a rising edge.
      queue_sample(8'hFF, 32'd10, 4'd0, 16'hFFFF);
      queue_sample(8'hFE, 32'd909, 4'd1, 16'h0000);        // 899: too short
      queue_sample(8'hFC, 32'd910, 4'd2, 16'h1234);        // 900: kept, off
      queue_sample(8'hF8, 32'd2210, 4'd3, 16'h0000);       // 2200: kept, on
      queue_sample(8'hF0, 32'd2211, 4'd4, 16'h0000);       // 2201: too long
      queue_sample(8'hE0, 32'd1310, 4'd5, 16'h0000);       // at the off level
      queue_sample(8'hC0, 32'd1311, 4'd6, 16'h0000);       // inside the band
      queue_sample(8'h80, 32'd1710, 4'd7, 16'h0000);       // at the on level
      queue_sample(8'h00, 32'd1709, 4'd8, 16'h0000);       // just below on
      queue_sample(8'h00, 32'd500000, 4'd1, 16'h0000);     // age equals timeout
      queue_sample(8'h00, 32'd500001, 4'd4, 16'hFFFF);     // one past timeout
      queue_sample(8'h00, 32'd500001, 4'd9, 16'hABCD);     // query above range
      queue_sample(8'h00, 32'd500001, 4'd15, 16'h5555);
      // A pulse that straddles the timestamp wrap, all lines at once.
      queue_sample(8'hFF, 32'hFFFF_FC00, 4'd3, 16'h0000);
      queue_sample(8'h00, 32'h0000_01DC, 4'd3, 16'h0000);
      queue_sample(8'h00, 32'hFFFF_FFFF, 4'd2, 16'hFFFF);
      queue_sample(8'h00, 32'h0000_01DC + 32'd500000, 4'd8, 16'h0000);
      queue_sample(8'h00, 32'h0000_01DC + 32'd500001, 4'd8, 16'h0000);
      queue_sample(8'h55, 32'd600000, 4'd1, 16'h0000);
      queue_sample(8'hAA, 32'd601000, 4'd2, 16'h0000);
      queue_sample(8'h00, 32'd603000, 4'd2, 16'h0000);
      queue_sample(8'hFF, 32'd700000, 4'd5, 16'h0000);
      queue_sample(8'h00, 32'd703000, 4'd5, 16'h0000);     // far too long
      gen_levels = 8'h00;
      gen_now    = 32'd800000;
      queue_random_samples(200);

      run_phase(32'd16777215, 32'd900, 32'd2200, 84, 0, 215, 1'b0, 1'b0);
      run_phase(32'd1, 32'd1500, 32'd1500, 0, 84, 215, 1'b0, 1'b0);
      run_phase(32'd20000, 32'd2000, 32'd1000, 10, 10, 215, 1'b1, 1'b0);
      run_phase(32'd500000, 32'd1300, 32'd1700, 10, 10, 215, 1'b0, 1'b1);
      run_phase(32'($urandom_range(16777215, 1)), 32'($urandom_range(2200, 900)),
                32'($urandom_range(2200, 900)), 0, 0, 215, 1'b0, 1'b0);
      wait_idle();

      $display("Checked %0d responses for %0d samples under %0d register writes.",
               rsp_count, accepted_count, csr_count);
      $display("Covered timeout extremes, equal and crossed switch levels, wrap and idling.");
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("** rc_pwm_pulse_capture: PASSED **");
      end else begin
         $display("** rc_pwm_pulse_capture: FAILED **");
      end
      $finish;
   end

endmodule
